// File: hdl/eoh_pkg.sv
`default_nettype none

package eoh_pkg;

  // Default sizes of the histogram and the orbit store
  localparam int BINS_X_DEF    = 256;
  localparam int BINS_Y_DEF    = 256;
  localparam int MAX_ORBIT_DEF = 1024;

  // Fixed field widths
  localparam int DATA_W     = 32;
  localparam int BIN_IN_W   = 8;
  localparam int ITER_W     = 11;
  localparam int HITS_W     = 12;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Q4.28 arithmetic
  localparam int FRAC_W = 28;
  localparam int SUM_W  = 38;
  localparam logic [63:0] ESC_THRESH = 64'd4 << 56;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN    = 3'd0,
    CFG_X_MAX    = 3'd1,
    CFG_Y_MIN    = 3'd2,
    CFG_Y_MAX    = 3'd3,
    CFG_MAX_ITER = 3'd4,
    CFG_SYM      = 3'd5
  } cfg_idx_t;

  // Register reset values
  localparam logic signed [DATA_W-1:0] X_MIN_RST = 32'shE0000000;
  localparam logic signed [DATA_W-1:0] X_MAX_RST = 32'sh10000000;
  localparam logic signed [DATA_W-1:0] Y_MIN_RST = 32'shF0000000;
  localparam logic signed [DATA_W-1:0] Y_MAX_RST = 32'sh10000000;
  localparam logic [ITER_W-1:0]        MAX_ITER_RST = 11'd1024;
  localparam logic                     SYM_RST = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_BIN,
    ST_MUL,
    ST_CHK,
    ST_WALK_RD,
    ST_WALK_MAP,
    ST_WALK_WAIT,
    ST_BUMP_RD,
    ST_BUMP_WR,
    ST_MIRR_RD,
    ST_MIRR_WR,
    ST_NEXT,
    ST_FIN
  } eoh_state_t;

  // Histogram address source
  typedef enum logic [1:0] {
    ADDR_READ,
    ADDR_BUMP,
    ADDR_MIRR,
    ADDR_CLR
  } addr_sel_t;

  typedef struct packed {
    logic      load_item;
    logic      mul;
    logic      step;
    logic      escape;
    logic      orb_rd;
    logic      map_start;
    logic      k_dec;
    logic      hist_rd;
    logic      hist_wr;
    addr_sel_t addr_sel;
    logic      hit_inc;
    logic      clr_adv;
    logic      out_load;
  } eoh_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic mag_gt;
    logic cont;
    logic k_one;
    logic map_busy;
    logic map_hit;
    logic sym;
    logic clr_last;
  } eoh_sts_t;

endpackage

`default_nettype wire

// File: hdl/eoh_if.sv
`default_nettype none

// Sample and read request channel
interface eoh_in_if import eoh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [DATA_W-1:0] c_real;
  logic signed [DATA_W-1:0] c_imag;
  logic [BIN_IN_W-1:0]      bin_x;
  logic [BIN_IN_W-1:0]      bin_y;

  modport source (output valid, op, c_real, c_imag, bin_x, bin_y, input ready);
  modport sink   (input valid, op, c_real, c_imag, bin_x, bin_y, output ready);
endinterface

// Result channel
interface eoh_out_if import eoh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               escaped;
  logic [ITER_W-1:0]  escape_step;
  logic [HITS_W-1:0]  hits_added;
  logic [COUNT_W-1:0] bin_count;

  modport source (output valid, escaped, escape_step, hits_added, bin_count, input ready);
  modport sink   (input valid, escaped, escape_step, hits_added, bin_count, output ready);
endinterface

`default_nettype wire

// File: hdl/escape_orbit_histogram.sv
`default_nettype none
// Orbit histogram of escaping sample points.
// in_ch carries one transaction per item: op 0 traces the point c, op 1 reads the
// bin (bin_x, bin_y). out_ch returns exactly one result transaction per item.
// Configuration goes through cfg_we/cfg_idx/cfg_wdata, one register per cycle;
// the user must write it only while the block is idle; the block does not enforce it.
// After reset the histogram is cleared by a sweep over all BINS_X*BINS_Y bins
// (65536 at the default size); in_ch.ready stays low until it ends.
// A read is accepted in ST_IDLE, reads its bin in ST_RD_BIN and loads the result in ST_FIN.
// A trace runs each orbit step through ST_MUL (the three 32x32 multipliers) and
// ST_CHK (add/saturate and escape compare). An escaping orbit then walks back
// over its points through the bin mappers: each point is read from the orbit
// store, mapped by the bit-serial bin index divider and, on a hit, counted by a
// read and a write of its histogram bin, and of the mirrored bin if sym is set.
// One item is in work at a time. The result register lets the next item be
// accepted while a result waits; if the receiver stalls, a finished item holds
// in its last state until the result register frees.
module escape_orbit_histogram import eoh_pkg::*; #(
  parameter int BINS_X    = BINS_X_DEF,
  parameter int BINS_Y    = BINS_Y_DEF,
  parameter int MAX_ORBIT = MAX_ORBIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  eoh_in_if.sink                     in_ch,
  eoh_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  eoh_cmd_t cmd;
  eoh_sts_t sts;

  eoh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eoh_dp #(
    .BINS_X    (BINS_X),
    .BINS_Y    (BINS_Y),
    .MAX_ORBIT (MAX_ORBIT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_ch.op),
    .in_c_real       (in_ch.c_real),
    .in_c_imag       (in_ch.c_imag),
    .in_bin_x        (in_ch.bin_x),
    .in_bin_y        (in_ch.bin_y),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_escaped     (out_ch.escaped),
    .out_escape_step (out_ch.escape_step),
    .out_hits_added  (out_ch.hits_added),
    .out_bin_count   (out_ch.bin_count)
  );

  // An escaped trace has a nonzero step and no bin count
  a_esc_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.escaped |-> out_ch.escape_step != '0 && out_ch.bin_count == '0)
    else $error("escaped result with bad step or count");

  // Without escape there is no step and no hit
  a_noesc_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.escaped |-> out_ch.escape_step == '0 && out_ch.hits_added == '0)
    else $error("non-escaped result with step or hits");

  // Never restart the bin mappers while they run
  a_map_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.map_start |-> !sts.map_busy)
    else $error("bin mapper started while busy");

  // Histogram update only while walking an escaped orbit
  a_bump_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hit_inc |-> cmd.hist_wr && !in_ch.ready)
    else $error("histogram update outside the walk");

endmodule

`default_nettype wire

// File: hdl/eoh_bin_map.sv
`default_nettype none

module eoh_bin_map import eoh_pkg::*; #(
  parameter int NB = BINS_X_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [DATA_W-1:0] v,
  input  wire logic signed [DATA_W:0]   lo,
  input  wire logic signed [DATA_W:0]   hi,
  output logic                          busy,
  output logic                          hit,
  output logic [$clog2(NB)-1:0]         idx
);

  localparam int IW    = $clog2(NB);
  localparam int NB2_W = $clog2(2 * NB + 1);
  localparam int M1_W  = DATA_W + NB2_W;
  localparam int S_W   = M1_W + 1;
  localparam int NUM_W = S_W + IW;
  localparam int LAST  = IW + 2;
  localparam int CNT_W = $clog2(LAST + 1);

  localparam logic [NB2_W-1:0] NB2  = NB2_W'(2 * NB);
  localparam logic [IW-1:0]    NBM1 = IW'(NB - 1);

  localparam logic [CNT_W-1:0] PH_MUL  = CNT_W'(0);
  localparam logic [CNT_W-1:0] PH_ADD  = CNT_W'(1);
  localparam logic [CNT_W-1:0] PH_NUM  = CNT_W'(2);
  localparam logic [CNT_W-1:0] PH_LAST = CNT_W'(LAST);

  logic signed [DATA_W+1:0] v_x, lo_x, hi_x, off_x, span_x;
  logic                     inr_r, zsp_r, busy_r;
  logic [DATA_W-1:0]        d_r, span_r;
  logic [M1_W-1:0]          m1_r, dv_r;
  logic [S_W-1:0]           s_r;
  logic [NUM_W-1:0]         rem_r, dsh_r;
  logic [IW-1:0]            q_r;
  logic [CNT_W-1:0]         cnt_r;

  // Range check and offsets
  always_comb begin
    v_x    = (DATA_W+2)'(v);
    lo_x   = (DATA_W+2)'(lo);
    hi_x   = (DATA_W+2)'(hi);
    off_x  = v_x - lo_x;
    span_x = hi_x - lo_x;
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == PH_LAST) busy_r <= 1'b0;
    end
  end

  // Scale, then divide one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      inr_r  <= (v_x >= lo_x) && (v_x <= hi_x);
      zsp_r  <= (span_x == '0);
      d_r    <= off_x[DATA_W-1:0];
      span_r <= span_x[DATA_W-1:0];
    end else if (busy_r) begin
      if (cnt_r == PH_MUL) begin
        m1_r <= M1_W'(d_r) * M1_W'(NB2);
        dv_r <= M1_W'(span_r) * M1_W'(NB2);
      end else if (cnt_r == PH_ADD) begin
        s_r <= S_W'(m1_r) + S_W'(span_r);
      end else if (cnt_r == PH_NUM) begin
        rem_r <= NUM_W'(s_r) * NUM_W'(NBM1);
        dsh_r <= NUM_W'(dv_r) << (IW - 1);
        q_r   <= '0;
      end else begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[IW-2:0], 1'b1};
        end else begin
          q_r <= {q_r[IW-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
    end
  end

  assign busy = busy_r;
  assign hit  = inr_r;
  assign idx  = zsp_r ? '0 : q_r;

endmodule

`default_nettype wire

// File: hdl/eoh_dp.sv
`default_nettype none

module eoh_dp import eoh_pkg::*; #(
  parameter int BINS_X    = BINS_X_DEF,
  parameter int BINS_Y    = BINS_Y_DEF,
  parameter int MAX_ORBIT = MAX_ORBIT_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_op,
  input  wire logic signed [DATA_W-1:0] in_c_real,
  input  wire logic signed [DATA_W-1:0] in_c_imag,
  input  wire logic [BIN_IN_W-1:0]      in_bin_x,
  input  wire logic [BIN_IN_W-1:0]      in_bin_y,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  wire eoh_cmd_t                 cmd,
  output eoh_sts_t                      sts,
  output logic                          out_escaped,
  output logic [ITER_W-1:0]             out_escape_step,
  output logic [HITS_W-1:0]             out_hits_added,
  output logic [COUNT_W-1:0]            out_bin_count
);

  localparam int XW  = $clog2(BINS_X);
  localparam int YW  = $clog2(BINS_Y);
  localparam int HD  = BINS_X * BINS_Y;
  localparam int AW  = $clog2(HD);
  localparam int OW  = $clog2(MAX_ORBIT);
  localparam int N_W = ($clog2(MAX_ORBIT + 1) > ITER_W) ? $clog2(MAX_ORBIT + 1) : ITER_W;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFFFFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh80000000);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_HI) r = 32'sh7FFFFFFF;
    else if (x < SAT_LO) r = 32'sh80000000;
    else r = $signed(x[DATA_W-1:0]);
    return r;
  endfunction

  // Configuration registers
  logic signed [DATA_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic [ITER_W-1:0]        max_iter_r;
  logic                     sym_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= X_MIN_RST;
      x_max_r    <= X_MAX_RST;
      y_min_r    <= Y_MIN_RST;
      y_max_r    <= Y_MAX_RST;
      max_iter_r <= MAX_ITER_RST;
      sym_r      <= SYM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_X_MIN:    x_min_r    <= $signed(cfg_wdata);
        CFG_X_MAX:    x_max_r    <= $signed(cfg_wdata);
        CFG_Y_MIN:    y_min_r    <= $signed(cfg_wdata);
        CFG_Y_MAX:    y_max_r    <= $signed(cfg_wdata);
        CFG_MAX_ITER: max_iter_r <= cfg_wdata[ITER_W-1:0];
        CFG_SYM:      sym_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Transaction and orbit state
  logic                     op_r, esc_r;
  logic signed [DATA_W-1:0] cr_r, ci_r, zr_r, zi_r;
  logic [BIN_IN_W-1:0]      bx_r, by_r;
  logic [N_W-1:0]           n_r, n_p1, lim;
  logic [OW-1:0]            k_r;
  logic [HITS_W-1:0]        hits_r;
  logic signed [63:0]       sq_rr_r, sq_ii_r, sq_ri_r;
  logic signed [63:0]       re_shf, im_shf;
  logic signed [SUM_W-1:0]  re_sum, im_sum;
  logic signed [DATA_W-1:0] zr_new, zi_new;
  logic [63:0]              mag;

  // Next orbit point and escape test
  always_comb begin
    re_shf = (sq_rr_r - sq_ii_r) >>> FRAC_W;
    im_shf = sq_ri_r >>> (FRAC_W - 1);
    re_sum = SUM_W'(re_shf) + SUM_W'(cr_r);
    im_sum = SUM_W'(im_shf) + SUM_W'(ci_r);
    zr_new = sat32(re_sum);
    zi_new = sat32(im_sum);
    mag    = $unsigned(sq_rr_r) + $unsigned(sq_ii_r);
    n_p1   = n_r + 1'b1;
  end

  // Clamp the orbit length
  always_comb begin
    if (N_W'(max_iter_r) > N_W'(MAX_ORBIT)) lim = N_W'(MAX_ORBIT);
    else if (max_iter_r == '0) lim = N_W'(1);
    else lim = N_W'(max_iter_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_op;
      cr_r   <= in_c_real;
      ci_r   <= in_c_imag;
      bx_r   <= in_bin_x;
      by_r   <= in_bin_y;
      zr_r   <= in_c_real;
      zi_r   <= in_c_imag;
      n_r    <= '0;
      esc_r  <= 1'b0;
      hits_r <= '0;
    end
    if (cmd.mul) begin
      sq_rr_r <= 64'(zr_r) * 64'(zr_r);
      sq_ii_r <= 64'(zi_r) * 64'(zi_r);
      sq_ri_r <= 64'(zr_r) * 64'(zi_r);
    end
    if (cmd.step) begin
      zr_r <= zr_new;
      zi_r <= zi_new;
      n_r  <= n_p1;
    end
    if (cmd.escape) begin
      esc_r <= 1'b1;
      k_r   <= OW'(n_r - N_W'(1));
    end
    if (cmd.k_dec) k_r <= k_r - 1'b1;
    if (cmd.hit_inc) hits_r <= hits_r + 1'b1;
  end

  // Orbit store
  logic signed [DATA_W-1:0] orb_re_mem [MAX_ORBIT];
  logic signed [DATA_W-1:0] orb_im_mem [MAX_ORBIT];
  logic signed [DATA_W-1:0] orb_re_q_r, orb_im_q_r;

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      orb_re_mem[n_p1[OW-1:0]] <= zr_new;
      orb_im_mem[n_p1[OW-1:0]] <= zi_new;
    end
    if (cmd.orb_rd) begin
      orb_re_q_r <= orb_re_mem[k_r];
      orb_im_q_r <= orb_im_mem[k_r];
    end
  end

  // Bin mapping for both axes
  logic signed [DATA_W:0] y_lo;
  logic                   x_busy, y_busy, x_hit, y_hit;
  logic [XW-1:0]          x_idx;
  logic [YW-1:0]          y_idx, y_mir;

  assign y_lo  = sym_r ? -(DATA_W+1)'(y_max_r) : (DATA_W+1)'(y_min_r);
  assign y_mir = YW'(BINS_Y - 1) - y_idx;

  eoh_bin_map #(.NB(BINS_X)) u_map_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.map_start),
    .v     (orb_re_q_r),
    .lo    ((DATA_W+1)'(x_min_r)),
    .hi    ((DATA_W+1)'(x_max_r)),
    .busy  (x_busy),
    .hit   (x_hit),
    .idx   (x_idx)
  );

  eoh_bin_map #(.NB(BINS_Y)) u_map_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.map_start),
    .v     (orb_im_q_r),
    .lo    (y_lo),
    .hi    ((DATA_W+1)'(y_max_r)),
    .busy  (y_busy),
    .hit   (y_hit),
    .idx   (y_idx)
  );

  // Histogram address and write data
  logic [AW-1:0]      clr_r, haddr, rd_addr, bump_addr, mirr_addr;
  logic [COUNT_W-1:0] hist_q_r, hwdata;
  logic               rd_inr;

  always_comb begin
    rd_addr   = AW'(by_r) * AW'(BINS_X) + AW'(bx_r);
    bump_addr = AW'(y_idx) * AW'(BINS_X) + AW'(x_idx);
    mirr_addr = AW'(y_mir) * AW'(BINS_X) + AW'(x_idx);
    rd_inr    = (int'(bx_r) < BINS_X) && (int'(by_r) < BINS_Y);
    case (cmd.addr_sel)
      ADDR_READ: haddr = rd_addr;
      ADDR_BUMP: haddr = bump_addr;
      ADDR_MIRR: haddr = mirr_addr;
      ADDR_CLR:  haddr = clr_r;
      default:   haddr = clr_r;
    endcase
    if (cmd.addr_sel == ADDR_CLR) hwdata = '0;
    else if (&hist_q_r) hwdata = hist_q_r;
    else hwdata = hist_q_r + 1'b1;
  end

  // Histogram store
  logic [COUNT_W-1:0] hist_mem [HD];

  always_ff @(posedge clk) begin
    if (cmd.hist_wr) hist_mem[haddr] <= hwdata;
    if (cmd.hist_rd) hist_q_r <= hist_mem[haddr];
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_adv) clr_r <= clr_r + 1'b1;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (op_r) begin
        out_escaped     <= 1'b0;
        out_escape_step <= '0;
        out_hits_added  <= '0;
        out_bin_count   <= rd_inr ? hist_q_r : '0;
      end else begin
        out_escaped     <= esc_r;
        out_escape_step <= esc_r ? ITER_W'(n_r) : '0;
        out_hits_added  <= hits_r;
        out_bin_count   <= '0;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts.n_zero   = (n_r == '0);
    sts.n_one    = (n_r == N_W'(1));
    sts.mag_gt   = (mag > ESC_THRESH);
    sts.cont     = (n_p1 < lim);
    sts.k_one    = (k_r == OW'(1));
    sts.map_busy = x_busy | y_busy;
    sts.map_hit  = x_hit & y_hit;
    sts.sym      = sym_r;
    sts.clr_last = (clr_r == AW'(HD - 1));
  end

endmodule

`default_nettype wire

// File: hdl/eoh_ctrl.sv
`default_nettype none

module eoh_ctrl import eoh_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire eoh_sts_t sts,
  output eoh_cmd_t      cmd
);

  eoh_state_t state_r, state_nxt;
  logic       out_valid_r, out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // State and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:     if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:      if (in_valid) state_nxt = in_op ? ST_RD_BIN : ST_MUL;
      ST_RD_BIN:    state_nxt = ST_FIN;
      ST_MUL:       state_nxt = ST_CHK;
      ST_CHK: begin
        if (!sts.n_zero && sts.mag_gt) state_nxt = sts.n_one ? ST_FIN : ST_WALK_RD;
        else if (sts.cont) state_nxt = ST_MUL;
        else state_nxt = ST_FIN;
      end
      ST_WALK_RD:   state_nxt = ST_WALK_MAP;
      ST_WALK_MAP:  state_nxt = ST_WALK_WAIT;
      ST_WALK_WAIT: if (!sts.map_busy) state_nxt = sts.map_hit ? ST_BUMP_RD : ST_NEXT;
      ST_BUMP_RD:   state_nxt = ST_BUMP_WR;
      ST_BUMP_WR:   state_nxt = sts.sym ? ST_MIRR_RD : ST_NEXT;
      ST_MIRR_RD:   state_nxt = ST_MIRR_WR;
      ST_MIRR_WR:   state_nxt = ST_NEXT;
      ST_NEXT:      state_nxt = sts.k_one ? ST_FIN : ST_WALK_RD;
      ST_FIN:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    cmd.addr_sel = ADDR_READ;
    case (state_r)
      ST_CLEAR: begin
        cmd.addr_sel = ADDR_CLR;
        cmd.hist_wr  = 1'b1;
        cmd.clr_adv  = 1'b1;
      end
      ST_IDLE:     cmd.load_item = in_valid;
      ST_RD_BIN:   cmd.hist_rd = 1'b1;
      ST_MUL:      cmd.mul = 1'b1;
      ST_CHK: begin
        if (!sts.n_zero && sts.mag_gt) cmd.escape = 1'b1;
        else if (sts.cont) cmd.step = 1'b1;
      end
      ST_WALK_RD:  cmd.orb_rd = 1'b1;
      ST_WALK_MAP: cmd.map_start = 1'b1;
      ST_BUMP_RD: begin
        cmd.addr_sel = ADDR_BUMP;
        cmd.hist_rd  = 1'b1;
      end
      ST_BUMP_WR: begin
        cmd.addr_sel = ADDR_BUMP;
        cmd.hist_wr  = 1'b1;
        cmd.hit_inc  = 1'b1;
      end
      ST_MIRR_RD: begin
        cmd.addr_sel = ADDR_MIRR;
        cmd.hist_rd  = 1'b1;
      end
      ST_MIRR_WR: begin
        cmd.addr_sel = ADDR_MIRR;
        cmd.hist_wr  = 1'b1;
        cmd.hit_inc  = 1'b1;
      end
      ST_NEXT:     cmd.k_dec = !sts.k_one;
      ST_FIN:      cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
